// ===== rtl/core/wtcd_pkg.sv =====
package wtcd_pkg;

  localparam int unsigned ALPHABET_DEPTH_DEF = 256;

  localparam int unsigned SYM_W      = 7;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned KEY3_W     = 24;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned LEN_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = KEY3_W;
  localparam int unsigned PROD3_W    = KEY3_W + SYM_W;
  localparam int unsigned PA_W       = KEY_W + SYM_W;
  localparam int unsigned PAB_W      = PA_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_THIRD  = 2'd2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [LEN_W-1:0] LEN_NONE   = 2'd0;
  localparam logic [LEN_W-1:0] LEN_SINGLE = 2'd1;
  localparam logic [LEN_W-1:0] LEN_PAIR   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_TRIPLE = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]   sym_first;
    logic [SYM_W-1:0]   sym_second;
    logic [SYM_W-1:0]   sym_third;
    logic [LEN_W-1:0]   match_len;
    logic [COUNT_W-1:0] alphabet_count;
    logic               table_full;
  } out_item_t;

  // Token that walks the cell chain: a duplicate probe or a third-symbol search.
  typedef struct packed {
    logic              vld;
    logic              probe;
    logic [CODE_W-1:0] val;
    logic              hit;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  sym_a;
    logic [SYM_W-1:0]  sym_b;
  } token_t;

endpackage

// ===== rtl/core/wtcd_cell.sv =====
module wtcd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wtcd_pkg::token_t           tok_i,
  output wtcd_pkg::token_t           tok_o,
  input  logic                       wr_en_i,
  input  logic [wtcd_pkg::SYM_W-1:0] wr_sym_i,
  input  logic [wtcd_pkg::KEY3_W-1:0] key_third_i
);
  import wtcd_pkg::*;

  logic               valid_q;
  logic [SYM_W-1:0]   sym_q;
  logic [PROD3_W-1:0] prod_q;
  token_t             tok_q;
  token_t             tok_d;
  logic [CODE_W-1:0]  cmp_val;

  // Compare against the raw symbol for a probe, the weighted symbol otherwise.
  assign cmp_val = tok_i.probe ? CODE_W'(sym_q) : CODE_W'(prod_q);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.hit && valid_q && (tok_i.val == cmp_val)) begin
      tok_d.hit = 1'b1;
      tok_d.sym = sym_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q <= 1'b1;
      end
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sym_q <= wr_sym_i;
    end
    prod_q <= PROD3_W'(key_third_i) * PROD3_W'(sym_q);
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/core/wtcd_chain.sv =====
module wtcd_chain #(
  parameter int unsigned DEPTH = wtcd_pkg::ALPHABET_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wtcd_pkg::token_t            tok_i,
  output wtcd_pkg::token_t            tok_o,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  input  logic [wtcd_pkg::SYM_W-1:0]  wr_sym_i,
  input  logic [wtcd_pkg::KEY3_W-1:0] key_third_i
);
  import wtcd_pkg::*;

  token_t tok_w [DEPTH+1];

  assign tok_w[0] = tok_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    wtcd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok_w[k]),
      .tok_o       (tok_w[k+1]),
      .wr_en_i     (wr_en_i && (wr_idx_i == IDX_W'(k))),
      .wr_sym_i    (wr_sym_i),
      .key_third_i (key_third_i)
    );
  end

  assign tok_o = tok_w[DEPTH];

endmodule

// ===== rtl/core/weighted_triple_code_decoder.sv =====
// Add item: a probe walks the cell chain between accept and result.
// Decode item: for n stored symbols the sweep issues one (a,b) pair per cycle over all n*n
// pairs, then a drain lets the last tokens leave the cell chain. Decode on an empty table
// goes straight to the result. One item at a time; the result register frees
// the input side while a result waits. Reset (rst_ni low, async) empties the alphabet
// and sets key_first to 1, key_second and key_third to 0; the table needs no clearing.
module weighted_triple_code_decoder #(
  parameter int unsigned ALPHABET_DEPTH = wtcd_pkg::ALPHABET_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wtcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wtcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wtcd_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wtcd_pkg::out_item_t             out_data_o
);
  import wtcd_pkg::*;

  localparam int unsigned IDX_W     = $clog2(ALPHABET_DEPTH);
  localparam int unsigned CNT_W     = $clog2(ALPHABET_DEPTH + 1);
  localparam int unsigned DRAIN_LEN = ALPHABET_DEPTH + 4;
  localparam int unsigned DRN_W     = $clog2(DRAIN_LEN + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PROBE = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Key registers
  logic [KEY_W-1:0]  key1_q;
  logic [KEY_W-1:0]  key2_q;
  logic [KEY3_W-1:0] key3_q;

  // Alphabet fill count and the symbol memory used for the pair sweep
  logic [CNT_W-1:0] size_q, size_d;
  logic [SYM_W-1:0] mem [ALPHABET_DEPTH];
  logic [SYM_W-1:0] rd_a_q, rd_b_q;

  // Current item
  logic [CODE_W-1:0] code_q;
  logic [SYM_W-1:0]  isym_q;
  logic              last_q;
  logic              is_add_q;
  logic              full_q, full_d;
  logic              launch_q, launch_d;

  // Sweep counters and product pipeline
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [IDX_W-1:0] last_idx;
  logic             p1_vld_q, p1_jz_q;
  logic             p2_vld_q, p2_jz_q;
  logic [SYM_W-1:0] a2_q, b2_q;
  logic [PA_W-1:0]  pa_q, pb_q;
  logic [PAB_W-1:0] pab;
  logic             fits;

  // First matches found so far
  logic             tri_q, tri_d, pair_q, pair_d, single_q, single_d;
  logic [SYM_W-1:0] t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  logic [SYM_W-1:0] p1s_q, p1s_d, p2s_q, p2s_d, s1_q, s1_d;

  logic [DRN_W-1:0] drain_q, drain_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  out_item_t res;

  token_t chain_in, chain_out;
  logic   app_en;
  logic   accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign last_idx   = IDX_W'(size_q - CNT_W'(1));

  // Stage C: pair sum, tail checks and token for the third-symbol search
  assign pab  = PAB_W'(pa_q) + PAB_W'(pb_q);
  assign fits = (CODE_W'(pab) <= code_q);

  always_comb begin
    chain_in = '0;
    if (launch_q) begin
      chain_in.vld   = 1'b1;
      chain_in.probe = 1'b1;
      chain_in.val   = CODE_W'(isym_q);
    end else begin
      chain_in.vld   = p2_vld_q && fits;
      chain_in.val   = code_q - CODE_W'(pab);
      chain_in.sym_a = a2_q;
      chain_in.sym_b = b2_q;
    end
  end

  wtcd_chain #(
    .DEPTH (ALPHABET_DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (chain_in),
    .tok_o       (chain_out),
    .wr_en_i     (app_en),
    .wr_idx_i    (size_q[IDX_W-1:0]),
    .wr_sym_i    (isym_q),
    .key_third_i (key3_q)
  );

  // Append when the probe comes back without a hit, the symbol is nonzero and there is room
  assign app_en = (state_q == ST_PROBE) && chain_out.vld && !chain_out.hit &&
                  (isym_q != '0) && (size_q < CNT_W'(ALPHABET_DEPTH));

  // Result assembly
  always_comb begin
    res                = '0;
    res.alphabet_count = COUNT_W'(size_q);
    if (is_add_q) begin
      res.table_full = full_q;
    end else if (tri_q) begin
      res.sym_first  = t1_q;
      res.sym_second = t2_q;
      res.sym_third  = t3_q;
      res.match_len  = LEN_TRIPLE;
    end else if (last_q && pair_q) begin
      res.sym_first  = p1s_q;
      res.sym_second = p2s_q;
      res.match_len  = LEN_PAIR;
    end else if (last_q && single_q) begin
      res.sym_first = s1_q;
      res.match_len = LEN_SINGLE;
    end else begin
      res.match_len = LEN_NONE;
    end
  end

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    full_d      = full_q;
    launch_d    = 1'b0;
    i_d         = i_q;
    j_d         = j_q;
    drain_d     = drain_q;
    tri_d       = tri_q;
    pair_d      = pair_q;
    single_d    = single_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    t3_d        = t3_q;
    p1s_d       = p1s_q;
    p2s_d       = p2s_q;
    s1_d        = s1_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    // Drop the result once it has been taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Record the first triple, pair and single in scan order
    if ((state_q == ST_SWEEP || state_q == ST_DRAIN) && chain_out.vld &&
        chain_out.hit && !tri_q) begin
      tri_d = 1'b1;
      t1_d  = chain_out.sym_a;
      t2_d  = chain_out.sym_b;
      t3_d  = chain_out.sym;
    end
    if (p2_vld_q && (CODE_W'(pab) == code_q) && !pair_q) begin
      pair_d = 1'b1;
      p1s_d  = a2_q;
      p2s_d  = b2_q;
    end
    if (p2_vld_q && p2_jz_q && (CODE_W'(pa_q) == code_q) && !single_q) begin
      single_d = 1'b1;
      s1_d     = a2_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          tri_d    = 1'b0;
          pair_d   = 1'b0;
          single_d = 1'b0;
          full_d   = 1'b0;
          i_d      = '0;
          j_d      = '0;
          if (in_data_i.cmd == CMD_ADD) begin
            launch_d = 1'b1;
            state_d  = ST_PROBE;
          end else if (size_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_PROBE: begin
        if (chain_out.vld) begin
          if (app_en) begin
            size_d = size_q + CNT_W'(1);
          end else if (!chain_out.hit && (isym_q != '0)) begin
            full_d = 1'b1;
          end
          state_d = ST_DONE;
        end
      end
      ST_SWEEP: begin
        if (j_q == last_idx) begin
          j_d = '0;
          if (i_q == last_idx) begin
            drain_d = '0;
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + DRN_W'(1);
        if (drain_q == DRN_W'(DRAIN_LEN - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key1_q      <= KEY_W'(1);
      key2_q      <= '0;
      key3_q      <= '0;
      size_q      <= '0;
      launch_q    <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      tri_q       <= 1'b0;
      pair_q      <= 1'b0;
      single_q    <= 1'b0;
      full_q      <= 1'b0;
      drain_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY_FIRST:  key1_q <= cfg_data_i[KEY_W-1:0];
          CFG_KEY_SECOND: key2_q <= cfg_data_i[KEY_W-1:0];
          CFG_KEY_THIRD:  key3_q <= cfg_data_i[KEY3_W-1:0];
          default:        ;
        endcase
      end
      state_q     <= state_d;
      size_q      <= size_d;
      launch_q    <= launch_d;
      p1_vld_q    <= (state_q == ST_SWEEP);
      p2_vld_q    <= p1_vld_q;
      out_valid_q <= out_valid_d;
      tri_q       <= tri_d;
      pair_q      <= pair_d;
      single_q    <= single_d;
      full_q      <= full_d;
      drain_q     <= drain_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  // Payload registers and the symbol memory
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q   <= in_data_i.code_word;
      isym_q   <= in_data_i.symbol;
      last_q   <= in_data_i.is_last;
      is_add_q <= (in_data_i.cmd == CMD_ADD);
    end
    if (app_en) begin
      mem[size_q[IDX_W-1:0]] <= isym_q;
    end
    rd_a_q  <= mem[i_q];
    rd_b_q  <= mem[j_q];
    p1_jz_q <= (j_q == '0);
    p2_jz_q <= p1_jz_q;
    a2_q    <= rd_a_q;
    b2_q    <= rd_b_q;
    pa_q    <= PA_W'(key1_q) * PA_W'(rd_a_q);
    pb_q    <= PA_W'(key2_q) * PA_W'(rd_b_q);
    t1_q    <= t1_d;
    t2_q    <= t2_d;
    t3_q    <= t3_d;
    p1s_q   <= p1s_d;
    p2s_q   <= p2s_d;
    s1_q    <= s1_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
